// File: rtl/dmi_pkg.sv
// Shared types, codes and helpers for the decelerating move integrator.
// No dependencies; every other file imports this package.
package dmi_pkg;

	localparam int DATA_W = 32;
	localparam int TIME_W = 16;
	localparam int OP_W   = 3;
	localparam int WIDE_W = 67;   // signed room for products, quotients and sums
	localparam int DIV_W  = 64;   // dividend magnitude width
	localparam int DVR_W  = 34;   // divisor magnitude width
	localparam int REM_W  = DVR_W + 1;
	localparam int CNT_W  = $clog2(DIV_W);

	localparam logic [OP_W-1:0] OP_TICK = 3'd0;
	localparam logic [OP_W-1:0] OP_MOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_POS  = 3'd2;
	localparam logic [OP_W-1:0] OP_VEL  = 3'd3;
	localparam logic [OP_W-1:0] OP_ACC  = 3'd4;

	localparam logic [DVR_W-1:0]  MS_PER_S   = 34'd1000;
	localparam logic signed [32:0] TWO_MS    = 33'sd2000;
	localparam logic signed [DATA_W-1:0] STOP_SPEED = 32'sd2560;

	typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} top_state_t;

	typedef enum logic [2:0] {
		L_IDLE, L_MUL_A, L_DIV_A_GO, L_DIV_A_WAIT, L_MUL_B, L_DIV_B_GO, L_DIV_B_WAIT
	} lane_state_t;

	typedef struct packed {
		logic                     start;
		logic                     is_move;
		logic [TIME_W-1:0]        t;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] acc;
		logic signed [DATA_W-1:0] dest;
	} lane_cmd_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] acc;
	} lane_res_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(64'sh7FFF_FFFF);
		lo = -WIDE_W'(64'sh8000_0000);
		if (v > hi) return 32'sh7FFF_FFFF;
		else if (v < lo) return 32'sh8000_0000;
		else return v[DATA_W-1:0];
	endfunction

endpackage

// File: rtl/dmi_in_if.sv
// Input channel: one item (op and operands) per beat.
// Depends on dmi_pkg for field widths.
interface dmi_in_if;
	import dmi_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value_x;
	logic signed [DATA_W-1:0] value_y;
	logic [TIME_W-1:0]        move_time_ms;
	logic [TIME_W-1:0]        tick_ms;

	modport source (output valid, op, value_x, value_y, move_time_ms, tick_ms, input ready);
	modport sink   (input valid, op, value_x, value_y, move_time_ms, tick_ms, output ready);
endinterface

// File: rtl/dmi_out_if.sv
// Output channel: body state after each item, one beat per item.
// Depends on dmi_pkg for field widths.
interface dmi_out_if;
	import dmi_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;
	logic signed [DATA_W-1:0] vel_x;
	logic signed [DATA_W-1:0] vel_y;
	logic                     moving;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, moving, input ready);
	modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, moving, output ready);
endinterface

// File: rtl/dmi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dmi_pkg for widths.
module dmi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dmi_pkg::DIV_W-1:0]  dividend,
	input  logic [dmi_pkg::DVR_W-1:0]  divisor,
	output logic                       done,
	output logic [dmi_pkg::DIV_W-1:0]  quotient
);
	import dmi_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVR_W-1:0] dvr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] rem_sh;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, dvr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvr_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/dmi_lane.sv
// One axis lane: shared multiplier plus iterative divider, sequenced twice
// per item (position then velocity for a tick, velocity then accel for a move).
// Depends on dmi_pkg and dmi_div.
module dmi_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  dmi_pkg::lane_cmd_t cmd,
	output dmi_pkg::lane_res_t res
);
	import dmi_pkg::*;

	lane_state_t state_q, state_nx;

	logic                     mv_q;
	logic [TIME_W-1:0]        t_q;
	logic signed [DATA_W-1:0] pos_q, vel_q, acc_q, dest_q, v_q;
	logic signed [2*33-1:0]   prod_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] rpos_q, rvel_q, racc_q;

	logic signed [32:0]       d, ma, mb, d_abs;
	logic                     dz;
	logic signed [2*33-1:0]   prod;
	logic [DIV_W-1:0]         mag;
	logic [DVR_W-1:0]         dvr;
	logic                     div_start, div_done, in_b, neg;
	logic [DIV_W-1:0]         quo;
	logic signed [WIDE_W-1:0] qs;
	logic signed [DATA_W-1:0] vnew;

	always_comb begin
		d     = {dest_q[DATA_W-1], dest_q} - {pos_q[DATA_W-1], pos_q};
		d_abs = d[32] ? -d : d;
		dz    = d == '0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			L_IDLE:       if (cmd.start) state_nx = L_MUL_A;
			L_MUL_A:      state_nx = L_DIV_A_GO;
			L_DIV_A_GO:   state_nx = L_DIV_A_WAIT;
			L_DIV_A_WAIT: if (div_done) state_nx = L_MUL_B;
			L_MUL_B:      state_nx = L_DIV_B_GO;
			L_DIV_B_GO:   state_nx = L_DIV_B_WAIT;
			L_DIV_B_WAIT: if (div_done) state_nx = L_IDLE;
			default:      state_nx = L_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		div_start = (state_q == L_DIV_A_GO) || (state_q == L_DIV_B_GO);
		in_b      = (state_q == L_MUL_B) || (state_q == L_DIV_B_GO) ||
		            (state_q == L_DIV_B_WAIT);
		if (state_q == L_MUL_B) begin
			ma = mv_q ? 33'(v_q) : 33'(acc_q);
			mb = mv_q ? 33'(v_q) : $signed({17'b0, t_q});
		end else begin
			ma = mv_q ? d : 33'(vel_q);
			mb = mv_q ? TWO_MS : $signed({17'b0, t_q});
		end
		if (!mv_q) dvr = MS_PER_S;
		else if (in_b) dvr = {d_abs[32:0], 1'b0};
		else dvr = {18'b0, t_q};
	end

	assign prod = ma * mb;
	assign mag  = prod_q[65] ? 64'(-prod_q) : 64'(prod_q);
	assign neg  = prod_q[65] ^ (mv_q & in_b & d[32]);
	assign qs   = neg ? -$signed({3'b0, quo}) : $signed({3'b0, quo});
	assign vnew = sat32(WIDE_W'(vel_q) + qs);

	dmi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (dvr),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == L_DIV_B_WAIT) && div_done;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && cmd.start) begin
			mv_q   <= cmd.is_move;
			t_q    <= cmd.t;
			pos_q  <= cmd.pos;
			vel_q  <= cmd.vel;
			acc_q  <= cmd.acc;
			dest_q <= cmd.dest;
		end
		if (state_q == L_MUL_A || state_q == L_MUL_B) prod_q <= prod;
		if (state_q == L_DIV_A_WAIT && div_done) begin
			if (mv_q) begin
				v_q    <= dz ? '0 : sat32(qs);
				rpos_q <= pos_q;
			end else begin
				rpos_q <= sat32(WIDE_W'(pos_q) + qs);
			end
		end
		if (state_q == L_DIV_B_WAIT && div_done) begin
			if (mv_q) begin
				rvel_q <= v_q;
				racc_q <= dz ? '0 : sat32(-qs);
			end else if (vnew > -STOP_SPEED && vnew < STOP_SPEED) begin
				// drop slow axis to rest
				rvel_q <= '0;
				racc_q <= '0;
			end else begin
				rvel_q <= vnew;
				racc_q <= acc_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.pos  = rpos_q;
	assign res.vel  = rvel_q;
	assign res.acc  = racc_q;
endmodule

// File: rtl/decelerating_move_integrator.sv
// Top level: two axis lanes plus the merge stage that owns the body state.
// Depends on dmi_pkg, dmi_in_if, dmi_out_if and dmi_lane.
//
// Usage: items arrive on cmd (valid/ready); each gives exactly one beat on
// rsp carrying position, velocity and the moving flag after the item.
// Loads, undefined ops and a move_to of zero time finish at once: the
// result is offered the cycle after acceptance.
// Ticks and timed move_to items run both axis lanes side by side; each lane
// does two multiply steps and two 64-step restoring divisions before the
// result beat is offered. One item is in flight at a time: cmd.ready is
// high only while no item is being worked on and no result waits. A stalled
// receiver holds the result beat stable and keeps cmd blocked until rsp is
// taken.
// Reset clears all body state (position, velocity, acceleration,
// destination, move timer) to zero and empties the block.
module decelerating_move_integrator (
	input logic         clk,
	input logic         arst_n,
	dmi_in_if.sink      cmd,
	dmi_out_if.source   rsp
);
	import dmi_pkg::*;

	top_state_t state_q, state_nx;

	logic signed [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [DATA_W-1:0] acc_x_q, acc_y_q, dest_x_q, dest_y_q;
	logic [DATA_W-1:0]        elapsed_q;
	logic [TIME_W-1:0]        total_q;
	logic                     active_q;
	logic [OP_W-1:0]          op_q;
	logic [TIME_W-1:0]        dt_q;

	lane_cmd_t  lcmd_x, lcmd_y;
	lane_res_t  lres_x, lres_y;
	logic       accept, use_lanes, lane_done;
	logic [DATA_W:0]   e_sum;
	logic [DATA_W-1:0] e_new;

	assign accept    = cmd.valid && cmd.ready;
	assign use_lanes = (cmd.op == OP_TICK) ||
	                   (cmd.op == OP_MOVE && cmd.move_time_ms != '0);
	assign lane_done = lres_x.done;

	always_comb begin
		lcmd_x.start   = accept && use_lanes;
		lcmd_x.is_move = cmd.op == OP_MOVE;
		lcmd_x.t       = (cmd.op == OP_MOVE) ? cmd.move_time_ms : cmd.tick_ms;
		lcmd_x.pos     = pos_x_q;
		lcmd_x.vel     = vel_x_q;
		lcmd_x.acc     = acc_x_q;
		lcmd_x.dest    = cmd.value_x;
		lcmd_y         = lcmd_x;
		lcmd_y.pos     = pos_y_q;
		lcmd_y.vel     = vel_y_q;
		lcmd_y.acc     = acc_y_q;
		lcmd_y.dest    = cmd.value_y;
	end

	dmi_lane u_lane_x (.clk(clk), .arst_n(arst_n), .cmd(lcmd_x), .res(lres_x));
	dmi_lane u_lane_y (.clk(clk), .arst_n(arst_n), .cmd(lcmd_y), .res(lres_y));

	always_comb begin
		e_sum = {1'b0, elapsed_q} + {{(DATA_W + 1 - TIME_W){1'b0}}, dt_q};
		e_new = e_sum[DATA_W] ? '1 : e_sum[DATA_W-1:0];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			T_IDLE:  if (accept) state_nx = use_lanes ? T_BUSY : T_OUT;
			T_BUSY:  if (lane_done) state_nx = T_OUT;
			T_OUT:   if (rsp.ready) state_nx = T_IDLE;
			default: state_nx = T_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		cmd.ready  = state_q == T_IDLE;
		rsp.valid  = state_q == T_OUT;
		rsp.pos_x  = pos_x_q;
		rsp.pos_y  = pos_y_q;
		rsp.vel_x  = vel_x_q;
		rsp.vel_y  = vel_y_q;
		rsp.moving = active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			dest_x_q  <= '0;
			dest_y_q  <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
			active_q  <= 1'b0;
			op_q      <= OP_TICK;
			dt_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				op_q <= cmd.op;
				dt_q <= cmd.tick_ms;
				unique case (cmd.op)
					OP_MOVE: begin
						dest_x_q  <= cmd.value_x;
						dest_y_q  <= cmd.value_y;
						elapsed_q <= '0;
						total_q   <= cmd.move_time_ms;
						active_q  <= cmd.move_time_ms != '0;
						if (cmd.move_time_ms == '0) begin
							// snap at once
							pos_x_q <= cmd.value_x;
							pos_y_q <= cmd.value_y;
							vel_x_q <= '0;
							vel_y_q <= '0;
							acc_x_q <= '0;
							acc_y_q <= '0;
						end
					end
					OP_POS: begin
						pos_x_q <= cmd.value_x;
						pos_y_q <= cmd.value_y;
					end
					OP_VEL: begin
						vel_x_q <= cmd.value_x;
						vel_y_q <= cmd.value_y;
					end
					OP_ACC: begin
						acc_x_q <= cmd.value_x;
						acc_y_q <= cmd.value_y;
					end
					default: ;
				endcase
			end
			if (state_q == T_BUSY && lane_done) begin
				vel_x_q <= lres_x.vel;
				vel_y_q <= lres_y.vel;
				acc_x_q <= lres_x.acc;
				acc_y_q <= lres_y.acc;
				if (op_q == OP_TICK) begin
					pos_x_q <= lres_x.pos;
					pos_y_q <= lres_y.pos;
					if (active_q) begin
						elapsed_q <= e_new;
						if (e_new >= {{(DATA_W - TIME_W){1'b0}}, total_q}) begin
							pos_x_q  <= dest_x_q;
							pos_y_q  <= dest_y_q;
							vel_x_q  <= '0;
							vel_y_q  <= '0;
							acc_x_q  <= '0;
							acc_y_q  <= '0;
							active_q <= 1'b0;
						end
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		lres_x.done == lres_y.done)
		else $error("axis lanes finished out of step");
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done |-> state_q == T_BUSY)
		else $error("lane result with no item in work");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && rsp.valid))
		else $error("input taken while a result waits");
	a_zero_move_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.op == OP_MOVE && cmd.move_time_ms == '0) |=> !active_q)
		else $error("zero-time move left the body moving");
`endif
endmodule

// File: bench/tb_top.sv
// Testbench for the decelerating move integrator: random and directed items,
// each result checked against a behavioral predictor of the body state.
// Depends on dmi_pkg, dmi_in_if, dmi_out_if and the top-level RTL.
module tb_top;
	import dmi_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, vx, vy;
		logic moving;
	} body_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   send_idle = 0;
	int   recv_idle = 0;

	dmi_in_if  cmd();
	dmi_out_if rsp();

	decelerating_move_integrator dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	class motion_scoreboard;
		logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, dst_x, dst_y;
		logic [31:0] elapsed;
		logic [15:0] total;
		logic active;
		body_t pending[$];

		function longint clamp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function logic signed [31:0] integrate(logic signed [31:0] base, logic signed [31:0] rate,
				logic [15:0] dt);
			longint d;
			d = (longint'(rate) * longint'({16'd0, dt})) / 1000;
			return 32'(clamp(longint'(base) + d));
		endfunction

		function void plan(logic signed [31:0] dst, logic signed [31:0] p, logic [15:0] t,
				output logic signed [31:0] v, output logic signed [31:0] a);
			longint d, vv, q;
			d = longint'(dst) - longint'(p);
			if (d == 0) begin
				v = 0;
				a = 0;
				return;
			end
			vv = clamp((2 * d * 1000) / longint'({16'd0, t}));
			q = (vv * vv) / (2 * d);
			v = 32'(vv);
			a = 32'(clamp(-q));
		endfunction

		function void snap();
			pos_x = dst_x;
			pos_y = dst_y;
			{vel_x, vel_y, acc_x, acc_y} = '0;
			active = 0;
		endfunction

		function void note_item(logic [2:0] op, logic signed [31:0] ax, logic signed [31:0] ay,
				logic [15:0] mt, logic [15:0] dt);
			longint e;
			body_t b;
			case (op)
				OP_TICK: begin
					pos_x = integrate(pos_x, vel_x, dt);
					pos_y = integrate(pos_y, vel_y, dt);
					vel_x = integrate(vel_x, acc_x, dt);
					vel_y = integrate(vel_y, acc_y, dt);
					if (vel_x > -STOP_SPEED && vel_x < STOP_SPEED) begin
						vel_x = 0;
						acc_x = 0;
					end
					if (vel_y > -STOP_SPEED && vel_y < STOP_SPEED) begin
						vel_y = 0;
						acc_y = 0;
					end
					if (active) begin
						e = longint'({32'd0, elapsed}) + dt;
						elapsed = (e > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(e);
						if (elapsed >= {16'd0, total}) snap();
					end
				end
				OP_MOVE: begin
					dst_x = ax;
					dst_y = ay;
					elapsed = 0;
					total = mt;
					active = 1;
					if (mt == 0) snap();
					else begin
						plan(dst_x, pos_x, mt, vel_x, acc_x);
						plan(dst_y, pos_y, mt, vel_y, acc_y);
					end
				end
				OP_POS: begin
					pos_x = ax;
					pos_y = ay;
				end
				OP_VEL: begin
					vel_x = ax;
					vel_y = ay;
				end
				OP_ACC: begin
					acc_x = ax;
					acc_y = ay;
				end
				default: ;
			endcase
			b.px = pos_x;
			b.py = pos_y;
			b.vx = vel_x;
			b.vy = vel_y;
			b.moving = active;
			pending.push_back(b);
		endfunction

		task check_result(body_t got);
			body_t w;
			if (pending.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			w = pending.pop_front();
			if (got.px !== w.px) report($sformatf("pos_x %h want %h", got.px, w.px));
			if (got.py !== w.py) report($sformatf("pos_y %h want %h", got.py, w.py));
			if (got.vx !== w.vx) report($sformatf("vel_x %h want %h", got.vx, w.vx));
			if (got.vy !== w.vy) report($sformatf("vel_y %h want %h", got.vy, w.vy));
			if (got.moving !== w.moving) report($sformatf("moving %b want %b", got.moving, w.moving));
		endtask
	endclass

	motion_scoreboard board = new();

	initial begin
		board.pos_x = 0; board.pos_y = 0; board.vel_x = 0; board.vel_y = 0;
		board.acc_x = 0; board.acc_y = 0; board.dst_x = 0; board.dst_y = 0;
		board.elapsed = 0; board.total = 0; board.active = 0;
	end

	// Drive one item; hold it until the beat is taken.
	task automatic send_item(logic [2:0] op, logic [31:0] ax, logic [31:0] ay,
			logic [15:0] mt, logic [15:0] dt);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.value_x <= ax;
		cmd.value_y <= ay;
		cmd.move_time_ms <= mt;
		cmd.tick_ms <= dt;
		do @(posedge clk); while (!cmd.ready);
		board.note_item(op, ax, ay, mt, dt);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			2: return 32'($signed($urandom_range(200000)) - 100000);
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	function automatic logic [15:0] rand_time();
		case ($urandom_range(4))
			0: return 16'($urandom);
			1: return 16'($urandom_range(3));
			default: return 16'($urandom_range(500));
		endcase
	endfunction

	task automatic random_item();
		int r;
		logic [2:0] op;
		r = $urandom_range(99);
		if (r < 55) op = OP_TICK;
		else if (r < 75) op = OP_MOVE;
		else if (r < 82) op = OP_POS;
		else if (r < 89) op = OP_VEL;
		else if (r < 96) op = OP_ACC;
		else op = 3'($urandom_range(7, 5));
		send_item(op, rand_value(), rand_value(), rand_time(), rand_time());
	endtask

	always @(posedge clk) begin
		body_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.px = rsp.pos_x;
			got.py = rsp.pos_y;
			got.vx = rsp.vel_x;
			got.vy = rsp.vel_y;
			got.moving = rsp.moving;
			board.check_result(got);
		end
		rsp.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
	end

	initial begin
		#10000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.op = OP_TICK;
		cmd.value_x = '0;
		cmd.value_y = '0;
		cmd.move_time_ms = '0;
		cmd.tick_ms = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, every op, zero tick, zero move time, undefined op
		send_item(OP_TICK, 0, 0, 0, 0);
		send_item(OP_VEL, 32'h7FFFFFFF, 32'h80000000, 0, 0);
		send_item(OP_ACC, 32'h7FFFFFFF, 32'h80000000, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 16'hFFFF);
		send_item(OP_TICK, 0, 0, 0, 16'hFFFF);
		send_item(OP_POS, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_MOVE, 32'h7FFFFFFF, 32'h80000000, 1, 0);
		send_item(OP_TICK, 0, 0, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 1);
		send_item(OP_MOVE, 32'h00001000, 32'hFFFFF000, 0, 0);
		send_item(OP_VEL, 2559, -2559, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 0);
		send_item(OP_VEL, 2560, -2560, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 0);
		send_item(OP_MOVE, 32'h00010000, 32'h00001000, 16'hFFFF, 0);
		send_item(OP_ACC, 5, 5, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 16'd30000);
		send_item(OP_TICK, 0, 0, 0, 16'd40000);
		send_item(OP_MOVE, 32'h00001000, 32'h00001000, 16'd100, 0);
		send_item(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
		send_item(3'd7, 0, 0, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 16'd100);
		cmd.valid <= 1'b0;

		// hold off until every result is back
		wait (board.pending.size() == 0);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 24 : (phase == 1) ? 86 : 0;
			recv_idle = (phase == 0) ? 86 : (phase == 1) ? 24 : 0;
			for (int i = 0; i < 610; i++) random_item();
		end
		cmd.valid <= 1'b0;

		wait (board.pending.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
